// ----- hdl/fr_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fr_pkg: shared types and constants of the fragment reassembler
// Field widths, register indexes, controller states and the command and
// status groups that join the controller to the datapath.
// ---------------------------------------------------------------------------
package fr_pkg;

	localparam int unsigned MAX_FRAGMENTS_DEF = 64;
	localparam int unsigned FRAGMENT_BYTES    = 8;

	localparam int unsigned MAC_W   = 48;
	localparam int unsigned ID_W    = 8;
	localparam int unsigned SEQ_W   = 8;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned TOTAL_W = 10;
	localparam int unsigned AGE_W   = 16;
	localparam int unsigned STAT_W  = 32;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HUB_MODE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

	localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd5000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT
	} fr_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;      // take the input beat into the capture registers
		logic tick;         // apply one tick to the open assembly
		logic frc_inc;      // count one received fragment
		logic tc_inc;       // count one timeout drop found at a fragment
		logic clear;        // drop the open assembly
		logic store;        // write the captured word into the store
		logic start;        // the stored word opens a new assembly
		logic emit;         // hand the assembly to the emission pipe
		logic load_single;  // put the captured fragment straight on the output
	} fr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic func;
		logic fin;
		logic seq_zero;
		logic hub;
		logic active;
		logic stale;
		logic id_match;
		logic seq_match;
		logic full;
		logic pipe_busy;
		logic out_free;
		logic reads_left;
	} fr_status_t;

endpackage

// ----- hdl/fr_ifs.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fr_ifs: stream channels of the fragment reassembler
// One interface for incoming fragment and tick beats, one for result beats.
// ---------------------------------------------------------------------------
interface fr_frag_if import fr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [MAC_W-1:0]  sender_mac;
	logic [ID_W-1:0]   command_id;
	logic [SEQ_W-1:0]  fragment_seq;
	logic              final_flag;
	logic [WORD_W-1:0] fragment_payload;

	modport source (output valid, func, sender_mac, command_id, fragment_seq,
		final_flag, fragment_payload, input ready);
	modport sink (input valid, func, sender_mac, command_id, fragment_seq,
		final_flag, fragment_payload, output ready);
endinterface

interface fr_result_if import fr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MAC_W-1:0]   out_mac;
	logic [ID_W-1:0]    out_command_id;
	logic [WORD_W-1:0]  out_payload;
	logic [IDX_W-1:0]   word_index;
	logic [TOTAL_W-1:0] total_bytes;
	logic               last_word;

	modport source (output valid, out_mac, out_command_id, out_payload, word_index,
		total_bytes, last_word, input ready);
	modport sink (input valid, out_mac, out_command_id, out_payload, word_index,
		total_bytes, last_word, output ready);
endinterface

// ----- hdl/fr_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ---------------------------------------------------------------------------
module fr_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- hdl/fr_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fr_ctrl: reassembler controller
// Takes one beat at a time, decides what it does to the assembly and
// waits while a finished message is read out of the store.
// ---------------------------------------------------------------------------
module fr_ctrl import fr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  fr_status_t status,
	output fr_cmd_t    cmd
);
	fr_state_t state_q, state_d;
	logic      live;
	logic      stale_drop;
	logic      bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		stale_drop = status.active && status.stale;
		live       = status.active && !status.stale;
		bad        = !status.id_match || !status.seq_match || status.full;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!status.func) begin
					cmd.tick = !status.hub;
					state_d  = ST_IDLE;
				end else if (status.hub) begin
					state_d = ST_IDLE;
				end else if (status.seq_zero && status.fin) begin
					// A single-frame message waits for the output path to drain.
					if (!status.pipe_busy && status.out_free) begin
						cmd.load_single = 1'b1;
						cmd.frc_inc     = 1'b1;
						state_d         = ST_IDLE;
					end
				end else begin
					cmd.frc_inc = 1'b1;
					cmd.tc_inc  = stale_drop;
					state_d     = ST_IDLE;
					if (!live && !status.seq_zero) begin
						cmd.clear = stale_drop;
					end else if (live && bad) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.store = 1'b1;
						cmd.start = !live;
						if (status.fin) begin
							cmd.emit = 1'b1;
							state_d  = ST_EMIT;
						end
					end
				end
			end
			ST_EMIT: begin
				if (!status.reads_left) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ----- hdl/fr_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fr_datapath: reassembler datapath
// Configuration, capture registers, assembly state, word store, emission
// pipe and output register.
// ---------------------------------------------------------------------------
module fr_datapath import fr_pkg::*; #(
	parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  fr_cmd_t               cmd,
	output fr_status_t            status,
	input  logic                  func,
	input  logic [MAC_W-1:0]      sender_mac,
	input  logic [ID_W-1:0]       command_id,
	input  logic [SEQ_W-1:0]      fragment_seq,
	input  logic                  final_flag,
	input  logic [WORD_W-1:0]     fragment_payload,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [MAC_W-1:0]      out_mac,
	output logic [ID_W-1:0]       out_command_id,
	output logic [WORD_W-1:0]     out_payload,
	output logic [IDX_W-1:0]      word_index,
	output logic [TOTAL_W-1:0]    total_bytes,
	output logic                  last_word
);
	localparam int unsigned AW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_FRAGMENTS + 1);

	// Configuration registers.
	logic             hub_q;
	logic [AGE_W-1:0] timeout_q;

	// Captured beat.
	logic              func_q;
	logic [MAC_W-1:0]  mac_q;
	logic [ID_W-1:0]   id_q;
	logic [SEQ_W-1:0]  seq_q;
	logic              fin_q;
	logic [WORD_W-1:0] word_q;

	// Open assembly.
	logic              active_q;
	logic [ID_W-1:0]   held_id_q;
	logic [MAC_W-1:0]  held_mac_q;
	logic [AGE_W-1:0]  age_q;
	logic [CW-1:0]     cnt_q;
	logic [STAT_W-1:0] frc_q;
	logic [STAT_W-1:0] tc_q;
	logic [AGE_W-1:0]  age_inc;
	logic              tick_drop;

	// Emission descriptor and read pointer.
	logic [MAC_W-1:0] emit_mac_q;
	logic [ID_W-1:0]  emit_id_q;
	logic [CW-1:0]    emit_cnt_q;
	logic [CW-1:0]    rd_ptr_q;
	logic             reads_left;
	logic             rd_en;

	// Read stage: the word itself sits in the RAM's read register.
	logic               v_s1;
	logic [MAC_W-1:0]   mac_s1;
	logic [ID_W-1:0]    id_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [TOTAL_W-1:0] total_s1;
	logic               last_s1;
	logic [WORD_W-1:0]  ram_rdata;

	// Output register.
	logic               out_valid_q;
	logic [MAC_W-1:0]   out_mac_q;
	logic [ID_W-1:0]    out_id_q;
	logic [WORD_W-1:0]  out_word_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               out_last_q;
	logic               out_free;
	logic               load_run;
	logic [AW-1:0]      ram_waddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hub_q     <= 1'b0;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HUB_MODE:      hub_q     <= cfg_data[0];
				REG_TIMEOUT_TICKS: timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			mac_q  <= sender_mac;
			id_q   <= command_id;
			seq_q  <= fragment_seq;
			fin_q  <= final_flag;
			word_q <= fragment_payload;
		end
	end

	assign age_inc   = (age_q == '1) ? age_q : age_q + 1'b1;
	assign tick_drop = cmd.tick && active_q && (age_inc > timeout_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			held_id_q  <= '0;
			held_mac_q <= '0;
			age_q      <= '0;
			cnt_q      <= '0;
		end else if (cmd.emit || cmd.clear || tick_drop) begin
			active_q   <= 1'b0;
			held_id_q  <= '0;
			held_mac_q <= '0;
			age_q      <= '0;
			cnt_q      <= '0;
		end else if (cmd.store && cmd.start) begin
			active_q   <= 1'b1;
			held_id_q  <= id_q;
			held_mac_q <= mac_q;
			age_q      <= '0;
			cnt_q      <= CW'(1);
		end else if (cmd.store) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.tick && active_q) begin
			age_q <= age_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frc_q <= '0;
			tc_q  <= '0;
		end else begin
			if (cmd.frc_inc) begin
				frc_q <= frc_q + 1'b1;
			end
			if (cmd.tc_inc || tick_drop) begin
				tc_q <= tc_q + 1'b1;
			end
		end
	end

	assign ram_waddr = cmd.start ? '0 : cnt_q[AW-1:0];

	fr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_FRAGMENTS)
	) u_store (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (ram_waddr),
		.wdata (word_q),
		.re    (rd_en),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign out_free   = !out_valid_q || out_ready;
	assign load_run   = v_s1 && out_free;
	assign reads_left = rd_ptr_q != emit_cnt_q;
	assign rd_en      = reads_left && (!v_s1 || load_run);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_cnt_q <= '0;
			rd_ptr_q   <= '0;
		end else if (cmd.emit) begin
			emit_cnt_q <= cmd.start ? CW'(1) : cnt_q + 1'b1;
			rd_ptr_q   <= '0;
		end else if (rd_en) begin
			rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			emit_mac_q <= cmd.start ? mac_q : held_mac_q;
			emit_id_q  <= cmd.start ? id_q : held_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rd_en) begin
			v_s1 <= 1'b1;
		end else if (load_run) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mac_s1   <= emit_mac_q;
			id_s1    <= emit_id_q;
			idx_s1   <= IDX_W'(rd_ptr_q);
			total_s1 <= TOTAL_W'(emit_cnt_q) * TOTAL_W'(FRAGMENT_BYTES);
			last_s1  <= (CW'(rd_ptr_q + 1'b1) == emit_cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_run || cmd.load_single) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_run) begin
			out_mac_q   <= mac_s1;
			out_id_q    <= id_s1;
			out_word_q  <= ram_rdata;
			out_idx_q   <= idx_s1;
			out_total_q <= total_s1;
			out_last_q  <= last_s1;
		end else if (cmd.load_single) begin
			out_mac_q   <= mac_q;
			out_id_q    <= id_q;
			out_word_q  <= word_q;
			out_idx_q   <= '0;
			out_total_q <= TOTAL_W'(FRAGMENT_BYTES);
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_mac        = out_mac_q;
	assign out_command_id = out_id_q;
	assign out_payload    = out_word_q;
	assign word_index     = out_idx_q;
	assign total_bytes    = out_total_q;
	assign last_word      = out_last_q;

	assign status.func       = func_q;
	assign status.fin        = fin_q;
	assign status.seq_zero   = (seq_q == '0);
	assign status.hub        = hub_q;
	assign status.active     = active_q;
	assign status.stale      = (age_q > timeout_q);
	assign status.id_match   = (id_q == held_id_q);
	assign status.seq_match  = (seq_q == SEQ_W'(cnt_q));
	assign status.full       = (cnt_q == CW'(MAX_FRAGMENTS));
	assign status.pipe_busy  = v_s1 || reads_left;
	assign status.out_free   = out_free;
	assign status.reads_left = reads_left;

	// A single-frame result must never overtake or collide with a run.
	a_single_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_single |-> (!v_s1 && !reads_left))
		else $error("single-frame load while the emission pipe is busy");

	// The store is never written while a message is still being read out.
	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !reads_left)
		else $error("store written during read-out");

	a_rd_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ptr_q <= emit_cnt_q)
		else $error("read pointer ran past the message length");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_FRAGMENTS))
		else $error("assembly word count exceeds the store depth");
endmodule

// ----- hdl/fragment_reassembler.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fragment_reassembler: command message reassembly with timeout
// Rebuilds one command message from in-order fragments and delivers it as
// a run of payload words; drops assemblies on error or inactivity.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake         Contents
//  frag      in         valid / ready     tick or fragment: func, sender_mac,
//                                         command_id, fragment_seq,
//                                         final_flag, fragment_payload
//  result    out        valid / ready     out_mac, out_command_id, out_payload,
//                                         word_index, total_bytes, last_word
//  cfg       in         cfg_we only       cfg_index 0 hub_mode, 1 timeout_ticks
//
//  A tick or a fragment that completes no message is taken in ST_IDLE and
//  acted on by the controller in ST_EXEC.
//  A final fragment then reads the message out of the word store, one word
//  a cycle while the receiver keeps up; the next beat waits until every
//  word has been read from the store.
//  A single-frame fragment is delivered from the capture registers and
//  waits only until the output register and the read stage are free.
//  The output register lets a new beat be taken while a result beat waits;
//  a stall on the result side holds the read-out pipe without loss.
//  Reset is asynchronous and active low and needs no clearing pass: the
//  word store is only read at addresses written by the current assembly.
//
module fragment_reassembler import fr_pkg::*; #(
	parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fr_frag_if.sink               frag,
	fr_result_if.source           result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	fr_cmd_t    cmd;
	fr_status_t status;
	logic       in_ready;

	// The controller owns the input handshake; all payload goes to the datapath.
	fr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frag.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign frag.ready = in_ready;

	// The datapath holds the assembly, the word store and the output register,
	// and drives the result channel directly.
	fr_datapath #(
		.MAX_FRAGMENTS (MAX_FRAGMENTS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.status           (status),
		.func             (frag.func),
		.sender_mac       (frag.sender_mac),
		.command_id       (frag.command_id),
		.fragment_seq     (frag.fragment_seq),
		.final_flag       (frag.final_flag),
		.fragment_payload (frag.fragment_payload),
		.out_valid        (result.valid),
		.out_ready        (result.ready),
		.out_mac          (result.out_mac),
		.out_command_id   (result.out_command_id),
		.out_payload      (result.out_payload),
		.word_index       (result.word_index),
		.total_bytes      (result.total_bytes),
		.last_word        (result.last_word)
	);
endmodule
